FILE: rtl/bfa_pkg.sv
// Package for the bitmap frame allocator: sizes, operation and status codes,
// the command and result transaction types, and the memory request type.
// It has no dependencies.
package bfa_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int WORD_BITS = 32;
    localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = $clog2(WORD_COUNT);
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int FRAME_W = 10;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_STATS = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NOT_READY     = 3'd1,
        ST_NO_SPACE      = 3'd2,
        ST_RANGE         = 3'd3,
        ST_NOT_ALLOCATED = 3'd4,
        ST_BAD_TOTAL     = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FRAME_W-1:0] frame;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] granted_frame;
        logic [COUNT_W-1:0] free_count;
    } t_result;

    typedef struct packed {
        logic                 clear;
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [ADDR_W-1:0]    raddr;
    } t_mem_req;

    // Position of the lowest clear bit of a bitmap word.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/bitmap_frame_allocator_unit.sv
// Top level of the bitmap first-fit frame allocator: command decode, scan and
// read-modify-write control around the usage bitmap memory.
// Depends on bfa_pkg and bfa_bitmap_mem.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  command   | in        | start high, busy low   | i_cmd (operation, frame)
//  result    | out       | o_done, one cycle      | o_result (status, granted
//            |           |                        |   frame, free count)
//  config    | in        | i_cfg_valid, o_cfg_ready | i_cfg_data (total frames)
//
// Init, statistics reads and rejected commands give their result in the cycle
// after the command transaction. A free reads the bitmap word and then writes it
// back. An allocate reads the bitmap words one after another through the single
// memory read port until the first word with a clear bit, or until the last word.
// Reset is synchronous and empties the bitmap.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bitmap_frame_allocator_unit
    import bfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_cmd               i_cmd,
    output logic               o_done,
    output t_result            o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [COUNT_W-1:0]   r_cfg_total;
    logic [COUNT_W-1:0]   r_total;
    logic [COUNT_W-1:0]   r_free;
    logic                 r_ready;
    logic [FRAME_W-1:0]   r_frame;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_cur;
    logic                 r_done;
    t_result              r_result;

    t_mem_req             mem_req;
    logic [WORD_BITS-1:0] rdata;
    logic                 accept;
    logic                 total_bad;
    logic [BIT_W-1:0]     zero_idx;
    logic [BIT_W-1:0]     free_bit;
    logic                 word_full;

    bfa_bitmap_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_result;

    assign total_bad = (r_cfg_total == '0) || (r_cfg_total > COUNT_W'(MAX_FRAMES));
    assign zero_idx  = lowest_zero(rdata);
    assign word_full = &rdata;
    assign free_bit  = r_frame[BIT_W-1:0];

    always_comb begin
        mem_req = '0;
        unique case (r_state)
            S_IDLE: begin
                mem_req.raddr = (t_op'(i_cmd.operation) == OP_FREE)
                              ? i_cmd.frame[FRAME_W-1:BIT_W] : '0;
                mem_req.clear = accept && t_op'(i_cmd.operation) == OP_INIT && !total_bad;
            end
            S_FREE: begin
                mem_req.waddr = r_frame[FRAME_W-1:BIT_W];
                mem_req.wdata = rdata & ~(WORD_BITS'(1) << free_bit);
                mem_req.we    = rdata[free_bit];
            end
            S_SCAN: begin
                mem_req.raddr = r_addr;
                mem_req.waddr = r_cur;
                mem_req.wdata = rdata | (WORD_BITS'(1) << zero_idx);
                mem_req.we    = !word_full;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_total <= COUNT_W'(MAX_FRAMES);
            r_total     <= '0;
            r_free      <= '0;
            r_ready     <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_total <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_result.granted_frame <= '0;
                        r_result.free_count    <= r_free;
                        r_result.status        <= ST_OK;
                        r_done                 <= 1'b1;
                        r_frame                <= i_cmd.frame;
                        if (t_op'(i_cmd.operation) == OP_INIT) begin
                            if (total_bad) begin
                                r_result.status <= ST_BAD_TOTAL;
                            end else begin
                                r_total             <= r_cfg_total;
                                r_free              <= r_cfg_total;
                                r_ready             <= 1'b1;
                                r_result.free_count <= r_cfg_total;
                            end
                        end else if (!r_ready) begin
                            r_result.status <= ST_NOT_READY;
                        end else if (t_op'(i_cmd.operation) == OP_ALLOC) begin
                            if (r_free == '0) begin
                                r_result.status <= ST_NO_SPACE;
                            end else begin
                                r_done  <= 1'b0;
                                r_cur   <= '0;
                                r_addr  <= ADDR_W'(1);
                                r_state <= S_SCAN;
                            end
                        end else if (t_op'(i_cmd.operation) == OP_FREE) begin
                            if (COUNT_W'(i_cmd.frame) >= r_total) begin
                                r_result.status <= ST_RANGE;
                            end else begin
                                r_done  <= 1'b0;
                                r_state <= S_FREE;
                            end
                        end
                    end
                end
                S_FREE: begin
                    r_done                 <= 1'b1;
                    r_result.granted_frame <= '0;
                    r_state                <= S_IDLE;
                    if (rdata[free_bit]) begin
                        r_free              <= r_free + COUNT_W'(1);
                        r_result.free_count <= r_free + COUNT_W'(1);
                        r_result.status     <= ST_OK;
                    end else begin
                        r_result.free_count <= r_free;
                        r_result.status     <= ST_NOT_ALLOCATED;
                    end
                end
                S_SCAN: begin
                    if (!word_full) begin
                        r_done                 <= 1'b1;
                        r_state                <= S_IDLE;
                        r_free                 <= r_free - COUNT_W'(1);
                        r_result.free_count    <= r_free - COUNT_W'(1);
                        r_result.granted_frame <= {r_cur, zero_idx};
                        r_result.status        <= ST_OK;
                    end else if (r_cur == ADDR_W'(WORD_COUNT - 1)) begin
                        r_done                 <= 1'b1;
                        r_state                <= S_IDLE;
                        r_result.free_count    <= r_free;
                        r_result.granted_frame <= '0;
                        r_result.status        <= ST_NO_SPACE;
                    end else begin
                        r_cur  <= r_cur + ADDR_W'(1);
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while an operation is still in progress");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_free <= r_total))
        else $error("free count exceeds the managed frame total");

    a_scan_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_free != '0))
        else $error("bitmap scan started with no free frames");

    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_op'(i_cmd.operation) == OP_INIT) |=> (o_done && r_ready == $past(r_ready || !total_bad)))
        else $error("init transaction did not complete in one cycle");

endmodule

FILE: rtl/bfa_bitmap_mem.sv
// Usage bitmap storage: one synchronous memory word per 32 frames, with a registered read.
// A valid bit per word lets a single clear request empty the whole bitmap.
// Depends on bfa_pkg.
module bfa_bitmap_mem
    import bfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_req             i_req,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_valid;
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[i_req.raddr];
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_frame_allocator_unit: directed and random commands,
// total-frames register writes between phases, and an allocator model that predicts each result in order.
// Depends on bfa_pkg and the RTL of the allocator.
module testbench;
    import bfa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 550;
    localparam int QUIET_FROM = 450;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_cmd               i_cmd = '0;
    logic               o_done;
    t_result            o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    t_cmd    pending_cmds[$];
    t_result awaited_results[$];

    logic [MAX_FRAMES-1:0] frame_used = '0;
    logic [COUNT_W-1:0]    model_free = '0;
    logic                  alloc_ready = 1'b0;
    logic [COUNT_W-1:0]    latched_total = '0;
    logic [COUNT_W-1:0]    total_reg = COUNT_W'(MAX_FRAMES);

    bit cmd_taken = 1'b0;
    bit gaps_on = 1'b1;
    int gap_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    bitmap_frame_allocator_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .o_done(o_done),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result allocator_step(t_cmd c);
        t_result r;
        r = '0;
        r.status = ST_OK;
        if (t_op'(c.operation) == OP_INIT) begin
            if (total_reg == 0 || total_reg > COUNT_W'(MAX_FRAMES)) begin
                r.status = ST_BAD_TOTAL;
            end else begin
                frame_used = '0;
                latched_total = total_reg;
                model_free = total_reg;
                alloc_ready = 1'b1;
            end
        end else if (!alloc_ready) begin
            r.status = ST_NOT_READY;
        end else if (t_op'(c.operation) == OP_ALLOC) begin
            r.status = ST_NO_SPACE;
            if (model_free != 0) begin
                for (int f = 0; f < MAX_FRAMES; f++) begin
                    if (f < latched_total && !frame_used[f]) begin
                        frame_used[f] = 1'b1;
                        model_free = model_free - 1'b1;
                        r.granted_frame = FRAME_W'(f);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
        end else if (t_op'(c.operation) == OP_FREE) begin
            if (COUNT_W'(c.frame) >= latched_total) begin
                r.status = ST_RANGE;
            end else if (!frame_used[c.frame]) begin
                r.status = ST_NOT_ALLOCATED;
            end else begin
                frame_used[c.frame] = 1'b0;
                model_free = model_free + 1'b1;
            end
        end
        r.free_count = model_free;
        return r;
    endfunction

    always @(negedge i_clk) begin
        logic nxt_start;
        t_cmd nxt_cmd;
        nxt_start = start;
        nxt_cmd = i_cmd;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!start || cmd_taken) begin
            nxt_start = 1'b0;
            if (cmd_taken && gaps_on && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(1, 4);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() > 0) begin
                nxt_start = 1'b1;
                nxt_cmd = pending_cmds.pop_front();
            end
        end
        cmd_taken = 1'b0;
        start <= nxt_start;
        i_cmd <= nxt_cmd;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_done) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: status %0d frame %0d free %0d",
                                 o_result.status, o_result.granted_frame, o_result.free_count);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.status !== want.status
                            || o_result.granted_frame !== want.granted_frame
                            || o_result.free_count !== want.free_count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected status %0d frame %0d free %0d, got %0d %0d %0d",
                                     want.status, want.granted_frame, want.free_count,
                                     o_result.status, o_result.granted_frame, o_result.free_count);
                        end
                    end
                end
            end
            if (start && !busy) begin
                awaited_results.push_back(allocator_step(i_cmd));
                cmd_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                total_reg = i_cfg_data;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_cmd(t_op op, int frame);
        t_cmd c;
        c.operation = op;
        c.frame = FRAME_W'(frame);
        pending_cmds.push_back(c);
    endtask

    task automatic settle();
        while (pending_cmds.size() > 0 || start || awaited_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_total(int value);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= COUNT_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        int total;
        int span;
        int count;
        int pick;
        int r;
        bit deep_done;
        sent = 0;
        deep_done = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(OP_ALLOC, 0);
        queue_cmd(OP_FREE, 0);
        queue_cmd(OP_STATS, 1023);
        queue_cmd(OP_FREE, 1023);
        write_total(0);
        queue_cmd(OP_INIT, 0);
        queue_cmd(OP_ALLOC, 0);
        write_total(2047);
        queue_cmd(OP_INIT, 0);
        queue_cmd(OP_STATS, 0);
        write_total(3);
        queue_cmd(OP_INIT, 682);
        queue_cmd(OP_ALLOC, 341);
        queue_cmd(OP_ALLOC, 0);
        queue_cmd(OP_ALLOC, 0);
        queue_cmd(OP_ALLOC, 0);
        queue_cmd(OP_FREE, 1);
        queue_cmd(OP_FREE, 1);
        queue_cmd(OP_FREE, 3);
        queue_cmd(OP_FREE, 1023);
        queue_cmd(OP_ALLOC, 0);
        write_total(0);
        queue_cmd(OP_INIT, 0);
        queue_cmd(OP_ALLOC, 0);
        queue_cmd(OP_STATS, 0);
        write_total(1024);
        queue_cmd(OP_FREE, 2);
        queue_cmd(OP_INIT, 0);
        queue_cmd(OP_FREE, 1023);

        while (sent < RANDOM_ITEMS) begin
            if (sent >= QUIET_FROM) begin
                gaps_on = 1'b0;
            end
            pick = $urandom_range(0, 9);
            if (!deep_done) begin
                total = MAX_FRAMES;
            end else if (pick == 0) begin
                total = 0;
            end else if (pick == 1) begin
                total = $urandom_range(MAX_FRAMES + 1, 2047);
            end else if (pick == 2) begin
                total = MAX_FRAMES;
            end else if (pick == 3) begin
                total = 1;
            end else begin
                total = $urandom_range(2, 48);
            end
            write_total(total);
            span = (total >= 1 && total <= MAX_FRAMES) ? total : 48;
            if (!deep_done || $urandom_range(0, 7) != 0) begin
                queue_cmd(OP_INIT, $urandom_range(0, 1023));
                sent++;
            end
            count = deep_done ? $urandom_range(10, 50) : 220;
            for (int i = 0; i < count; i++) begin
                r = $urandom_range(0, 99);
                if (r < (deep_done ? 48 : 80)) begin
                    queue_cmd(OP_ALLOC, $urandom_range(0, 1023));
                end else if (r < 90) begin
                    if ($urandom_range(0, 9) < 8) begin
                        queue_cmd(OP_FREE, $urandom_range(0, (span < 1024 ? span : 1024) - 1));
                    end else begin
                        queue_cmd(OP_FREE, $urandom_range(0, 1023));
                    end
                end else if (r < 95) begin
                    queue_cmd(OP_STATS, $urandom_range(0, 1023));
                end else begin
                    queue_cmd(OP_INIT, $urandom_range(0, 1023));
                end
                sent++;
            end
            deep_done = 1'b1;
        end

        settle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
